// ===== hw/rtl/ufr_pkg.sv =====
// Shared types, constants and codes of the upgrade frame receiver.
`default_nettype none
package ufr_pkg;

  localparam int unsigned MAX_FRAME_LEN_DEF = 2048;
  localparam int unsigned HDR_DEPTH         = 11;
  localparam int unsigned HDR_IW            = 4;
  localparam int unsigned FLEN_W            = 17;
  localparam int unsigned LEN_W             = 12;
  localparam int unsigned THRESH_W          = 26;
  localparam int unsigned OFFS_W            = 27;
  localparam int unsigned PLEN_W            = 11;
  localparam int unsigned HDR_LEN_ADD       = 4;
  localparam int unsigned DATA_HDR_LEN      = 8;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned US_PER_MS         = 1000;
  localparam int unsigned IN_W              = 40;
  localparam int unsigned OUT_W             = 152;
  localparam int unsigned KIND_W            = 2;

  localparam logic [7:0] SYNC0 = 8'hA5;
  localparam logic [7:0] SYNC1 = 8'h5A;

  localparam int unsigned TIMEOUT_RST = 200;
  localparam logic [THRESH_W-1:0] THRESH_RST =
    THRESH_W'(TIMEOUT_RST * US_PER_MS + US_PER_MS - 1);
  localparam logic [3:0]  CODE_START_RST   = 4'd1;
  localparam logic [3:0]  CODE_TOTALS_RST  = 4'd2;
  localparam logic [3:0]  CODE_DATA_RST    = 4'd3;
  localparam logic [3:0]  CODE_VERSION_RST = 4'd4;
  localparam logic [3:0]  DIR_LOCAL_RST    = 4'd0;
  localparam logic [11:0] PACKET_SIZE_RST  = 12'd1024;
  localparam logic [31:0] SOFT_VERSION_RST = 32'd0;

  typedef enum logic [2:0] {
    CFG_TIMEOUT      = 3'd0,
    CFG_CODE_START   = 3'd1,
    CFG_CODE_TOTALS  = 3'd2,
    CFG_CODE_DATA    = 3'd3,
    CFG_CODE_VERSION = 3'd4,
    CFG_DIR_LOCAL    = 3'd5,
    CFG_PACKET_SIZE  = 3'd6,
    CFG_SOFT_VERSION = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    CLS_START   = 3'd0,
    CLS_TOTALS  = 3'd1,
    CLS_DATA    = 3'd2,
    CLS_VERSION = 3'd3,
    CLS_UNKNOWN = 3'd4
  } frame_cls_e;

  typedef enum logic [1:0] {
    RK_ACK      = 2'd0,
    RK_VERSION  = 2'd1,
    RK_CSUM_ERR = 2'd2
  } reply_kind_e;

  typedef enum logic [1:0] {
    PS_IDLE        = 2'd0,
    PS_RECEIVING   = 2'd1,
    PS_DONE_LOCAL  = 2'd2,
    PS_DONE_REMOTE = 2'd3
  } prog_e;

  typedef struct packed {
    logic [THRESH_W-1:0] thresh;
    logic [3:0]          code_start;
    logic [3:0]          code_totals;
    logic [3:0]          code_data;
    logic [3:0]          code_version;
    logic [3:0]          dir_local;
    logic [11:0]         packet_size;
    logic [31:0]         soft_version;
  } cfg_t;

  typedef struct packed {
    frame_cls_e       cls;
    logic [7:0]       b4;
    logic [15:0]      seq;
    logic [31:0]      word;
    logic [LEN_W-1:0] len;
    logic             sum_ok;
  } frame_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ufr_fifo.sv =====
// Small flip-flop queue of completed frames between the front and back parts.
`default_nettype none
module ufr_fifo #(
  parameter int unsigned DEPTH = ufr_pkg::QUEUE_DEPTH
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire ufr_pkg::frame_t data_i,
  output logic                 full_o,
  output logic                 valid_o,
  output ufr_pkg::frame_t      data_o,
  input  wire logic            pop_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNTW = $clog2(DEPTH + 1);

  ufr_pkg::frame_t mem_q [DEPTH];
  logic [PW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CNTW'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ufr_front.sv =====
// Byte front end: timeout check, frame assembly, completion detection and classification.
`default_nettype none
module ufr_front #(
  parameter int unsigned MAX_FRAME_LEN = ufr_pkg::MAX_FRAME_LEN_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [ufr_pkg::IN_W-1:0]   s_axis_tdata,
  input  wire ufr_pkg::cfg_t              cfg_i,
  input  wire logic                       full_i,
  output logic                            push_o,
  output ufr_pkg::frame_t                 entry_o
);

  localparam int unsigned CW = $clog2(MAX_FRAME_LEN);

  logic [CW-1:0]  fc_q, fc_d, fc_eff, n;
  logic [7:0]     sum_q, sum_d, sum_eff;
  logic [31:0]    last_time_q, last_time_d, gap;
  logic [7:0]     hdr_q [ufr_pkg::HDR_DEPTH];
  logic [7:0]     hdr_d [ufr_pkg::HDR_DEPTH];
  logic [7:0]     hdr_eff [ufr_pkg::HDR_DEPTH];
  logic [7:0]     byte_in;
  logic [31:0]    time_in;
  logic [ufr_pkg::FLEN_W-1:0] flen;
  logic [3:0]     type_nib;
  logic           accept, tmo, done;

  assign byte_in       = s_axis_tdata[7:0];
  assign time_in       = s_axis_tdata[39:8];
  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    gap     = time_in - last_time_q;
    tmo     = gap > 32'(cfg_i.thresh);
    fc_eff  = tmo ? '0 : fc_q;
    sum_eff = tmo ? 8'd0 : sum_q;
    hdr_eff = hdr_q;
    if (fc_eff < CW'(ufr_pkg::HDR_DEPTH)) begin
      hdr_eff[fc_eff[ufr_pkg::HDR_IW-1:0]] = byte_in;
    end
    n    = fc_eff + 1'b1;
    flen = ufr_pkg::FLEN_W'({hdr_eff[2], hdr_eff[3]}) +
           ufr_pkg::FLEN_W'(ufr_pkg::HDR_LEN_ADD);
    done = (n > CW'(ufr_pkg::HDR_LEN_ADD)) && (ufr_pkg::FLEN_W'(n) == flen) &&
           (hdr_eff[0] == ufr_pkg::SYNC0) && (hdr_eff[1] == ufr_pkg::SYNC1);

    fc_d        = fc_q;
    sum_d       = sum_q;
    last_time_d = last_time_q;
    hdr_d       = hdr_q;
    if (accept) begin
      last_time_d = time_in;
      hdr_d       = hdr_eff;
      if (done || (n >= CW'(MAX_FRAME_LEN - 1))) begin
        fc_d  = '0;
        sum_d = 8'd0;
      end else begin
        fc_d  = n;
        sum_d = sum_eff + byte_in;
      end
    end

    type_nib = hdr_eff[4][3:0];
    priority if (type_nib == cfg_i.code_start) begin
      entry_o.cls = ufr_pkg::CLS_START;
    end else if (type_nib == cfg_i.code_totals) begin
      entry_o.cls = ufr_pkg::CLS_TOTALS;
    end else if (type_nib == cfg_i.code_data) begin
      entry_o.cls = ufr_pkg::CLS_DATA;
    end else if (type_nib == cfg_i.code_version) begin
      entry_o.cls = ufr_pkg::CLS_VERSION;
    end else begin
      entry_o.cls = ufr_pkg::CLS_UNKNOWN;
    end
    entry_o.b4     = hdr_eff[4];
    entry_o.seq    = {hdr_eff[5], hdr_eff[6]};
    entry_o.word   = {hdr_eff[7], hdr_eff[8], hdr_eff[9], hdr_eff[10]};
    entry_o.len    = ufr_pkg::LEN_W'(n);
    entry_o.sum_ok = (sum_eff == byte_in);
  end

  assign push_o = accept && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q        <= '0;
      sum_q       <= 8'd0;
      last_time_q <= 32'd0;
      for (int i = 0; i < ufr_pkg::HDR_DEPTH; i++) begin
        hdr_q[i] <= 8'd0;
      end
    end else begin
      fc_q        <= fc_d;
      sum_q       <= sum_d;
      last_time_q <= last_time_d;
      hdr_q       <= hdr_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ufr_back.sv =====
// Back end: carries out completed frames, keeps upgrade progress and holds the result register.
`default_nettype none
module ufr_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        valid_i,
  input  wire ufr_pkg::frame_t             entry_i,
  output logic                             pop_o,
  input  wire ufr_pkg::cfg_t               cfg_i,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [ufr_pkg::OUT_W-1:0]        m_axis_tdata,
  output logic [ufr_pkg::KIND_W-1:0]       m_axis_tuser
);

  logic [15:0]           ann_p_q, ann_p_d, recv_q, recv_d, recv_inc;
  logic [31:0]           ann_b_q, ann_b_d, ver;
  ufr_pkg::prog_e        prog_q, prog_d;
  ufr_pkg::reply_kind_e  kind;
  logic [7:0]            rtb;
  logic [27:0]           prod;
  logic [ufr_pkg::OFFS_W-1:0] offs;
  logic [ufr_pkg::PLEN_W-1:0] plen;
  logic [ufr_pkg::LEN_W-1:0]  len_sub;
  logic                  out_valid_q, out_valid_d;
  logic [ufr_pkg::OUT_W-1:0]  tdata_q;
  logic [ufr_pkg::KIND_W-1:0] tuser_q;

  assign pop_o         = valid_i && (!out_valid_q || m_axis_tready);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  always_comb begin
    ann_p_d  = ann_p_q;
    ann_b_d  = ann_b_q;
    recv_d   = recv_q;
    prog_d   = prog_q;
    kind     = ufr_pkg::RK_ACK;
    rtb      = 8'd0;
    offs     = '0;
    plen     = '0;
    ver      = 32'd0;
    recv_inc = recv_q + 16'd1;
    prod     = 28'(entry_i.seq) * 28'(cfg_i.packet_size);
    len_sub  = entry_i.len - ufr_pkg::LEN_W'(ufr_pkg::DATA_HDR_LEN);
    unique case (entry_i.cls)
      ufr_pkg::CLS_START: begin
        rtb = entry_i.b4;
      end
      ufr_pkg::CLS_TOTALS: begin
        rtb     = entry_i.b4;
        ann_p_d = entry_i.seq;
        ann_b_d = entry_i.word;
        recv_d  = 16'd0;
        prog_d  = ufr_pkg::PS_RECEIVING;
      end
      ufr_pkg::CLS_DATA: begin
        if (!entry_i.sum_ok) begin
          kind = ufr_pkg::RK_CSUM_ERR;
        end else begin
          rtb    = entry_i.b4;
          recv_d = recv_inc;
          offs   = prod[ufr_pkg::OFFS_W-1:0];
          if (entry_i.len > ufr_pkg::LEN_W'(ufr_pkg::DATA_HDR_LEN)) begin
            plen = len_sub[ufr_pkg::PLEN_W-1:0];
          end
          if ((ann_p_q != 16'd0) && (recv_inc >= ann_p_q) &&
              (entry_i.seq == ann_p_q - 16'd1)) begin
            prog_d = (entry_i.b4[7:4] == cfg_i.dir_local) ? ufr_pkg::PS_DONE_LOCAL
                                                          : ufr_pkg::PS_DONE_REMOTE;
          end
        end
      end
      ufr_pkg::CLS_VERSION: begin
        kind = ufr_pkg::RK_VERSION;
        rtb  = {4'd0, cfg_i.code_version};
        ver  = cfg_i.soft_version;
      end
      default: begin
      end
    endcase

    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ann_p_q     <= 16'd0;
      ann_b_q     <= 32'd0;
      recv_q      <= 16'd0;
      prog_q      <= ufr_pkg::PS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        ann_p_q <= ann_p_d;
        ann_b_q <= ann_b_d;
        recv_q  <= recv_d;
        prog_q  <= prog_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      tuser_q <= kind;
      tdata_q <= {ver, ann_b_d, ann_p_d, prog_d, plen, offs, entry_i.seq,
                  entry_i.b4[7:4], entry_i.b4[3:0], rtb};
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/upgrade_frame_receiver.sv =====
// Top level of the upgrade frame receiver: configuration registers and the part instances.
//
// The receiver takes one serial byte with its arrival time per cycle while the input is ready
// and gives one result per completed frame; a completed frame is first written into the queue
// and its result then into the back part's output register. The front part holds the frame
// count, the eleven header bytes and the running byte sum; completed frames pass through a
// two-entry queue to the back part, which keeps the upgrade progress and the announced totals.
// The input is ready whenever that queue has room, so byte intake stops only while results wait
// on a stalled output.
`default_nettype none
module upgrade_frame_receiver #(
  parameter int unsigned MAX_FRAME_LEN = ufr_pkg::MAX_FRAME_LEN_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // data_byte [7:0], time_us [39:8]
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire logic [ufr_pkg::IN_W-1:0]   s_axis_tdata,
  // reply_type_byte [7:0], type_nibble [11:8], direction [15:12], sequence_res [31:16],
  // write_offset [58:32], payload_length [69:59], upgrade_state [71:70],
  // total_packets [87:72], total_bytes [119:88], version_word [151:120]
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  output logic [ufr_pkg::OUT_W-1:0]       m_axis_tdata,
  // reply_kind [1:0]
  output logic [ufr_pkg::KIND_W-1:0]      m_axis_tuser,
  input  wire logic                       cfg_we_i,
  input  wire logic [2:0]                 cfg_addr_i,
  input  wire logic [31:0]                cfg_wdata_i
);

  ufr_pkg::cfg_t   cfg_q;
  ufr_pkg::frame_t push_entry, head_entry;
  logic            push, full, head_valid, pop;

  // The timeout is kept as a microsecond threshold so the byte path needs only a compare.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.thresh       <= ufr_pkg::THRESH_RST;
      cfg_q.code_start   <= ufr_pkg::CODE_START_RST;
      cfg_q.code_totals  <= ufr_pkg::CODE_TOTALS_RST;
      cfg_q.code_data    <= ufr_pkg::CODE_DATA_RST;
      cfg_q.code_version <= ufr_pkg::CODE_VERSION_RST;
      cfg_q.dir_local    <= ufr_pkg::DIR_LOCAL_RST;
      cfg_q.packet_size  <= ufr_pkg::PACKET_SIZE_RST;
      cfg_q.soft_version <= ufr_pkg::SOFT_VERSION_RST;
    end else if (cfg_we_i) begin
      unique case (ufr_pkg::cfg_idx_e'(cfg_addr_i))
        ufr_pkg::CFG_TIMEOUT: begin
          cfg_q.thresh <= ufr_pkg::THRESH_W'(32'(cfg_wdata_i[15:0]) *
                          32'(ufr_pkg::US_PER_MS) + 32'(ufr_pkg::US_PER_MS - 1));
        end
        ufr_pkg::CFG_CODE_START:   cfg_q.code_start   <= cfg_wdata_i[3:0];
        ufr_pkg::CFG_CODE_TOTALS:  cfg_q.code_totals  <= cfg_wdata_i[3:0];
        ufr_pkg::CFG_CODE_DATA:    cfg_q.code_data    <= cfg_wdata_i[3:0];
        ufr_pkg::CFG_CODE_VERSION: cfg_q.code_version <= cfg_wdata_i[3:0];
        ufr_pkg::CFG_DIR_LOCAL:    cfg_q.dir_local    <= cfg_wdata_i[3:0];
        ufr_pkg::CFG_PACKET_SIZE:  cfg_q.packet_size  <= cfg_wdata_i[11:0];
        ufr_pkg::CFG_SOFT_VERSION: cfg_q.soft_version <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  ufr_front #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .cfg_i        (cfg_q),
    .full_i       (full),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  ufr_fifo #(
    .DEPTH(ufr_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_entry),
    .full_o (full),
    .valid_o(head_valid),
    .data_o (head_entry),
    .pop_i  (pop)
  );

  ufr_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (head_valid),
    .entry_i      (head_entry),
    .pop_o        (pop),
    .cfg_i        (cfg_q),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
`default_nettype wire
